// ----- design/ordered_array_insert_delete_search_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ordered array store
// Shared shorthand for concurrent checks clocked by clk_i and held off by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_INSERT_DELETE_SEARCH_TOP_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_DELETE_SEARCH_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define OAIDS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("oaids assertion failed");

// A condition in one cycle that demands a consequence in the next.
`define OAIDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("oaids assertion failed");

`endif

// ----- design/oaids_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered array store package
// Sizes, command and status codes, and the controller/datapath link types.
// ----------------------------------------------------------------------------
package oaids_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int FIDX_W = 6;
  localparam int FILL_W = 7;

  // Width at which positions and counts are compared.
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_SEARCH = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic    load;
    logic    ptr_init;
    logic    rd_issue;
    logic    put;
    logic    cnt_clr;
    logic    cnt_dec;
    logic    res_load;
    status_e res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             full;
    logic             empty;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             pos_eq_cnt;
    logic             pos_is_last;
    logic             rd_last;
    logic             hit;
  } dp_stat_t;

endpackage

// ----- design/oaids_dp.sv -----
// ----------------------------------------------------------------------------
// Ordered array store datapath
// Entry memory, fill count, walk pointer, one-entry read pipeline and result.
// ----------------------------------------------------------------------------
`include "ordered_array_insert_delete_search_top_defines.svh"

module oaids_dp import oaids_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CMD_W-1:0]         in_cmd_i,
  input  logic [POS_W-1:0]         in_pos_i,
  input  logic signed [VAL_W-1:0]  in_val_i,
  input  dp_cmd_t                  ctl_i,
  output dp_stat_t                 stat_o,
  output logic [ST_W-1:0]          res_status_o,
  output logic [FIDX_W-1:0]        res_found_o,
  output logic signed [VAL_W-1:0]  res_value_o,
  output logic [FILL_W-1:0]        res_count_o
);

  logic [CMD_W-1:0]        op_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [VAL_W-1:0] key_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [IDX_W-1:0]        ptr_q, ptr_d;
  logic [IDX_W-1:0]        addr_q;
  logic signed [VAL_W-1:0] rdata_q;
  logic                    pend_q;
  logic signed [VAL_W-1:0] mem_q [CAPACITY];

  logic [CMP_W-1:0]        pos_x, cnt_x, ptr_x;
  logic                    shift_op;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  logic signed [VAL_W-1:0] mem_wd;

  logic [ST_W-1:0]         status_q;
  logic [FIDX_W-1:0]       found_q;
  logic signed [VAL_W-1:0] value_q;
  logic [FILL_W-1:0]       fill_q;

  assign pos_x    = CMP_W'(pos_q);
  assign cnt_x    = CMP_W'(count_q);
  assign ptr_x    = CMP_W'(ptr_q);
  assign shift_op = (op_q == CMD_INSERT) || (op_q == CMD_DELETE);

  always_comb begin
    stat_o.op          = op_q;
    stat_o.full        = count_q >= CNT_W'(CAPACITY);
    stat_o.empty       = count_q == '0;
    stat_o.pos_gt_cnt  = pos_x > cnt_x;
    stat_o.pos_ge_cnt  = pos_x >= cnt_x;
    stat_o.pos_eq_cnt  = pos_x == cnt_x;
    stat_o.pos_is_last = (pos_x + CMP_W'(1)) == cnt_x;
    // Insert walks down to the target position; delete and search walk up to
    // the last valid entry; an indexed read takes a single access.
    if (op_q == CMD_INSERT) begin
      stat_o.rd_last = ptr_x == pos_x;
    end else if (op_q == CMD_READ) begin
      stat_o.rd_last = 1'b1;
    end else begin
      stat_o.rd_last = (ptr_x + CMP_W'(1)) == cnt_x;
    end
    stat_o.hit = pend_q && (rdata_q == key_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q  <= in_cmd_i;
      pos_q <= in_pos_i;
      key_q <= in_val_i;
    end
  end

  // Walk pointer.
  always_comb begin
    ptr_d = ptr_q;
    if (ctl_i.ptr_init) begin
      case (op_q)
        CMD_INSERT: ptr_d = IDX_W'(cnt_x - CMP_W'(1));
        CMD_DELETE: ptr_d = IDX_W'(pos_x + CMP_W'(1));
        CMD_SEARCH: ptr_d = '0;
        default:    ptr_d = IDX_W'(pos_x);
      endcase
    end else if (ctl_i.rd_issue) begin
      if (op_q == CMD_INSERT) begin
        ptr_d = ptr_q - IDX_W'(1);
      end else begin
        ptr_d = ptr_q + IDX_W'(1);
      end
    end
  end

  // A shift write lands the entry read in the previous cycle one place up or down;
  // otherwise the key is placed at the append or insert position.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = key_q;
    if (pend_q && shift_op) begin
      mem_we = 1'b1;
      mem_wd = rdata_q;
      if (op_q == CMD_INSERT) begin
        mem_wa = addr_q + IDX_W'(1);
      end else begin
        mem_wa = addr_q - IDX_W'(1);
      end
    end else if (ctl_i.put) begin
      mem_we = 1'b1;
      if (op_q == CMD_APPEND) begin
        mem_wa = IDX_W'(cnt_x);
      end else begin
        mem_wa = IDX_W'(pos_x);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_issue) begin
      rdata_q <= mem_q[ptr_q];
      addr_q  <= ptr_q;
    end
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.cnt_clr) begin
      count_d = '0;
    end else if (ctl_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end else if (ctl_i.put) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      pend_q  <= ctl_i.rd_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      status_q <= ctl_i.res_code;
      fill_q   <= FILL_W'(count_q);
      if ((op_q == CMD_SEARCH) && (ctl_i.res_code == ST_OK)) begin
        found_q <= FIDX_W'(addr_q);
      end else begin
        found_q <= '0;
      end
      if ((op_q == CMD_READ) && (ctl_i.res_code == ST_OK)) begin
        value_q <= rdata_q;
      end else begin
        value_q <= '0;
      end
    end
  end

  assign res_status_o = status_q;
  assign res_found_o  = found_q;
  assign res_value_o  = value_q;
  assign res_count_o  = fill_q;

  `OAIDS_ASSERT(a_count_range, count_q <= CNT_W'(CAPACITY))
  `OAIDS_ASSERT(a_single_write, !(ctl_i.put && pend_q))
  `OAIDS_ASSERT(a_shift_in_bounds, (pend_q && shift_op) |-> (CNT_W'(mem_wa) <= count_q))
  `OAIDS_ASSERT_NEXT(a_put_grows, ctl_i.put, count_q == ($past(count_q) + CNT_W'(1)))

endmodule

// ----- design/oaids_ctrl.sv -----
// ----------------------------------------------------------------------------
// Ordered array store controller
// Sequences each command over the datapath and hands off the result item.
// ----------------------------------------------------------------------------
module oaids_ctrl import oaids_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  ctl_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_q, state_d;
  status_e    code_q, code_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d        = state_q;
    code_d         = code_q;
    in_ready_o     = 1'b0;
    ctl_o          = '0;
    ctl_o.res_code = code_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end

      S_CHECK: begin
        state_d = S_FIN;
        unique case (stat_i.op)
          CMD_CLEAR: begin
            ctl_o.cnt_clr = 1'b1;
            code_d        = ST_OK;
          end
          CMD_APPEND: begin
            if (stat_i.full) begin
              code_d = ST_FULL;
            end else begin
              state_d = S_PUT;
            end
          end
          CMD_INSERT: begin
            if (stat_i.pos_gt_cnt) begin
              code_d = ST_BADPOS;
            end else if (stat_i.full) begin
              code_d = ST_FULL;
            end else if (stat_i.pos_eq_cnt) begin
              state_d = S_PUT;
            end else begin
              ctl_o.ptr_init = 1'b1;
              state_d        = S_RUN;
            end
          end
          CMD_DELETE: begin
            if (stat_i.pos_ge_cnt) begin
              code_d = ST_BADPOS;
            end else if (stat_i.pos_is_last) begin
              // Removing the last entry moves nothing.
              ctl_o.cnt_dec = 1'b1;
              code_d        = ST_OK;
            end else begin
              ctl_o.ptr_init = 1'b1;
              state_d        = S_RUN;
            end
          end
          CMD_SEARCH: begin
            if (stat_i.empty) begin
              code_d = ST_NOTFOUND;
            end else begin
              ctl_o.ptr_init = 1'b1;
              state_d        = S_RUN;
            end
          end
          CMD_READ: begin
            if (stat_i.pos_ge_cnt) begin
              code_d = ST_BADPOS;
            end else begin
              ctl_o.ptr_init = 1'b1;
              state_d        = S_RUN;
            end
          end
          default: begin
            code_d = ST_BADPOS;
          end
        endcase
      end

      S_RUN: begin
        // A search stops at the first match; the read in flight is dropped.
        if ((stat_i.op == CMD_SEARCH) && stat_i.hit) begin
          code_d  = ST_OK;
          state_d = S_FIN;
        end else begin
          ctl_o.rd_issue = 1'b1;
          if (stat_i.rd_last) begin
            state_d = S_TAIL;
          end
        end
      end

      S_TAIL: begin
        state_d = S_FIN;
        code_d  = ST_OK;
        if (stat_i.op == CMD_SEARCH) begin
          code_d = stat_i.hit ? ST_OK : ST_NOTFOUND;
        end else if (stat_i.op == CMD_DELETE) begin
          ctl_o.cnt_dec = 1'b1;
        end else if (stat_i.op == CMD_INSERT) begin
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        ctl_o.put = 1'b1;
        code_d    = ST_OK;
        state_d   = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/ordered_array_insert_delete_search_top.sv -----
// ----------------------------------------------------------------------------
// Ordered array store, top level
// Positional store of signed 32-bit values with clear, append, insert,
// delete, search and indexed read commands.
// ----------------------------------------------------------------------------
// Each accepted item is one command and produces exactly one result item with
// a status, the fill count after the command, and the search index or read
// value where they apply. The entries sit in a single memory that gives one
// read and one write per cycle, and every command that touches entries walks
// them one per cycle through that port. With a target position p, an insert
// walks from the last entry down to p (nothing when p equals the count), a
// delete walks the entries above p (none for the last entry), a search walks
// up from index 0 to the first match or the last entry, and a read takes a
// single access. One command is in flight at a time; the next is accepted as
// soon as the previous one has been placed in the output register, even
// while its result waits there. The store needs no clearing after reset.
module ordered_array_insert_delete_search_top import oaids_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position[6:0], value[38:7], zero[39]
  input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // found_index[5:0], read_value[37:6],
                                      // fill_count[44:38], zero[47:45]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  dp_cmd_t                 ctl;
  dp_stat_t                stat;
  logic [ST_W-1:0]         res_status;
  logic [FIDX_W-1:0]       res_found;
  logic signed [VAL_W-1:0] res_value;
  logic [FILL_W-1:0]       res_count;

  oaids_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  oaids_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_cmd_i     (s_axis_tuser),
    .in_pos_i     (s_axis_tdata[6:0]),
    .in_val_i     (s_axis_tdata[38:7]),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .res_status_o (res_status),
    .res_found_o  (res_found),
    .res_value_o  (res_value),
    .res_count_o  (res_count)
  );

  assign m_axis_tdata = {3'b000, res_count, res_value, res_found};
  assign m_axis_tuser = res_status;

endmodule
